/* sv/bmg_pkg.sv */
// Shared constants and types for the Box-Muller Gaussian sample unit.
`default_nettype none

package bmg_pkg;

  localparam int unsigned SERIES_TERMS     = 8;
  localparam int unsigned RAD_FIXED_STAGES = 33;
  localparam int unsigned COS_LATENCY      = 28;

  localparam logic [28:0] TWO_LN2_Q28 = 29'd372130559;
  localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
  localparam logic [30:0] ONE_Q30     = 31'h4000_0000;

  // a*(a+1) divisors of the Taylor terms
  localparam logic [8:0] COS_DIV [SERIES_TERMS] =
    '{9'd2, 9'd12, 9'd30, 9'd56, 9'd90, 9'd132, 9'd182, 9'd240};
  localparam logic [8:0] SIN_DIV [SERIES_TERMS] =
    '{9'd6, 9'd20, 9'd42, 9'd72, 9'd110, 9'd156, 9'd210, 9'd272};

  typedef enum logic {
    CFG_MEAN = 1'b0,
    CFG_STD  = 1'b1
  } cfg_reg_e;

endpackage

`default_nettype wire

/* sv/bmg_radius.sv */
// Radius path: sqrt(-2 ln u1) through log2 by squaring and a restoring square root.
`default_nettype none

module bmg_radius
  import bmg_pkg::*;
#(
  parameter int unsigned UNIFORM_BITS = 32,
  localparam int unsigned XW   = UNIFORM_BITS + 1,
  localparam int unsigned EW   = $clog2(UNIFORM_BITS + 1),
  localparam int unsigned TW   = EW + 28,
  localparam int unsigned RW   = TW + 2,
  localparam int unsigned SB   = (RW + 28 + 1) / 2,
  localparam int unsigned NWID = 2 * SB,
  localparam int unsigned NWN  = XW + 31
) (
  input  wire logic                    clk_i,
  input  wire logic                    en_i,
  input  wire logic [UNIFORM_BITS-1:0] code_i,
  output logic      [SB-1:0]           s_o
);

  logic [XW-1:0]   x0_q, x1_q;
  logic [EW-1:0]   e1_d, e1_q;
  logic [NWN-1:0]  shifted;
  logic [30:0]     m_q  [29];
  logic [27:0]     f_q  [29];
  logic [EW-1:0]   ep_q [29];
  logic [TW-1:0]   t_q;
  logic [TW+29:0]  rprod;
  logic [NWID-1:0] n_q   [SB+1];
  logic [NWID-1:0] res_q [SB+1];

  always_comb begin
    e1_d = '0;
    for (int i = 0; i < XW; i++) begin
      if (x0_q[i]) e1_d = EW'(i);
    end
  end

  assign shifted = {x1_q, 31'b0} << (EW'(UNIFORM_BITS) - e1_q);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x0_q    <= {1'b0, code_i} + XW'(1);
      x1_q    <= x0_q;
      e1_q    <= e1_d;
      m_q[0]  <= shifted[NWN-1 -: 31];
      f_q[0]  <= '0;
      ep_q[0] <= e1_q;
    end
  end

  // one fraction bit of log2(m) per stage
  for (genvar k = 0; k < 28; k++) begin : g_sq
    localparam logic [27:0] FB = 28'd1 << (27 - k);
    logic [61:0] sq;
    assign sq = 62'(m_q[k]) * 62'(m_q[k]);
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        ep_q[k+1] <= ep_q[k];
        if (sq[61]) begin
          m_q[k+1] <= sq[61:31];
          f_q[k+1] <= f_q[k] | FB;
        end else begin
          m_q[k+1] <= sq[60:30];
          f_q[k+1] <= f_q[k];
        end
      end
    end
  end

  assign rprod = (TW+30)'(t_q) * (TW+30)'(TWO_LN2_Q28) + ((TW+30)'(1) << 27);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t_q      <= {EW'(UNIFORM_BITS) - ep_q[28], 28'b0} - TW'(f_q[28]);
      n_q[0]   <= NWID'({rprod[TW+29:28], 28'b0});
      res_q[0] <= '0;
    end
  end

  for (genvar i = 0; i < SB; i++) begin : g_sqrt
    localparam logic [NWID-1:0] BIT = NWID'(1) << (2 * (SB - 1 - i));
    logic [NWID:0] trial;
    assign trial = {1'b0, res_q[i]} + {1'b0, BIT};
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if ({1'b0, n_q[i]} >= trial) begin
          n_q[i+1]   <= n_q[i] - trial[NWID-1:0];
          res_q[i+1] <= (res_q[i] >> 1) + BIT;
        end else begin
          n_q[i+1]   <= n_q[i];
          res_q[i+1] <= res_q[i] >> 1;
        end
      end
    end
  end

  assign s_o = res_q[SB][SB-1:0];

endmodule

`default_nettype wire

/* sv/bmg_cosine.sv */
// Angle path: cos(2 pi u2) by quadrant fold and a pipelined Taylor series.
`default_nettype none

module bmg_cosine
  import bmg_pkg::*;
#(
  parameter int unsigned UNIFORM_BITS = 32
) (
  input  wire logic                    clk_i,
  input  wire logic                    en_i,
  input  wire logic [UNIFORM_BITS-1:0] code_i,
  output logic                         c_neg_o,
  output logic      [31:0]             c_mag_o
);

  logic [31:0] p;
  logic [1:0]  q0_q, q1_q;
  logic [29:0] r0_q;
  logic [60:0] zprod;
  logic [30:0] z1_q;
  logic [61:0] zsq;

  logic [31:0] z2_q   [SERIES_TERMS*3+1];
  logic        sel_q  [SERIES_TERMS*3+1];
  logic        neg_q  [SERIES_TERMS*3+1];
  logic [33:0] sum_q  [SERIES_TERMS*3+1];
  logic [30:0] term_q [SERIES_TERMS+1];
  logic [32:0] a_q    [SERIES_TERMS];
  logic [32:0] ab_q   [SERIES_TERMS];
  logic [32:0] q0d_q  [SERIES_TERMS];
  logic [33:0] fsum;
  logic [33:0] fabs;
  logic        fneg_q;
  logic [31:0] fmag_q;

  if (UNIFORM_BITS >= 32) begin : g_trunc
    assign p = code_i[UNIFORM_BITS-1 -: 32];
  end else begin : g_widen
    assign p = {code_i, (32 - UNIFORM_BITS)'(0)};
  end

  assign zprod = 61'(r0_q) * 61'(HALF_PI_Q30);
  assign zsq   = 62'(z1_q) * 62'(z1_q) + (62'(1) << 29);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      q0_q      <= p[31:30];
      r0_q      <= p[29:0];
      q1_q      <= q0_q;
      z1_q      <= zprod[60:30];
      z2_q[0]   <= zsq[61:30];
      sel_q[0]  <= q1_q[0];
      neg_q[0]  <= q1_q[1] ^ q1_q[0];
      term_q[0] <= q1_q[0] ? z1_q : ONE_Q30;
      sum_q[0]  <= q1_q[0] ? 34'(z1_q) : 34'(ONE_Q30);
    end
  end

  // three stages a term: product, reciprocal estimate, correction and accumulate
  for (genvar k = 0; k < SERIES_TERMS; k++) begin : g_term
    localparam int unsigned B = 3 * k;
    localparam logic [32:0] RC_COS = 33'((34'd1 << 33) / COS_DIV[k]);
    localparam logic [32:0] RC_SIN = 33'((34'd1 << 33) / SIN_DIV[k]);
    logic [62:0] tprod;
    logic [65:0] rprod;
    logic [41:0] back;
    logic [41:0] rem;
    logic [8:0]  dv;
    logic [32:0] qv;

    assign tprod = 63'(term_q[k]) * 63'(z2_q[B]) + (63'(1) << 29);
    assign rprod = 66'(a_q[k]) * 66'(sel_q[B+1] ? RC_SIN : RC_COS);
    assign dv    = sel_q[B+2] ? SIN_DIV[k] : COS_DIV[k];
    assign back  = 42'(q0d_q[k]) * 42'(dv);
    assign rem   = 42'(ab_q[k]) - back;
    assign qv    = (rem >= 42'(dv)) ? q0d_q[k] + 33'd1 : q0d_q[k];

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        a_q[k]       <= tprod[62:30];
        z2_q[B+1]    <= z2_q[B];
        sel_q[B+1]   <= sel_q[B];
        neg_q[B+1]   <= neg_q[B];
        sum_q[B+1]   <= sum_q[B];

        ab_q[k]      <= a_q[k];
        q0d_q[k]     <= rprod[65:33];
        z2_q[B+2]    <= z2_q[B+1];
        sel_q[B+2]   <= sel_q[B+1];
        neg_q[B+2]   <= neg_q[B+1];
        sum_q[B+2]   <= sum_q[B+1];

        term_q[k+1]  <= qv[30:0];
        z2_q[B+3]    <= z2_q[B+2];
        sel_q[B+3]   <= sel_q[B+2];
        neg_q[B+3]   <= neg_q[B+2];
        if ((k % 2) == 0) begin
          sum_q[B+3] <= sum_q[B+2] - 34'(qv[30:0]);
        end else begin
          sum_q[B+3] <= sum_q[B+2] + 34'(qv[30:0]);
        end
      end
    end
  end

  assign fsum = sum_q[SERIES_TERMS*3];
  assign fabs = fsum[33] ? -fsum : fsum;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      fneg_q <= neg_q[SERIES_TERMS*3] ? (!fsum[33] && (|fsum)) : fsum[33];
      fmag_q <= fabs[31:0];
    end
  end

  assign c_neg_o = fneg_q;
  assign c_mag_o = fmag_q;

endmodule

`default_nettype wire

/* sv/box_muller_gaussian_sample_unit.sv */
// Top level of the Box-Muller Gaussian sample unit (cosine branch).
// SB is the root width of the square root chain, one root bit per stage.
// Throughput: one word per cycle; the whole pipeline holds while the output word waits.
// Reset clears the valid bits, mean to 0 and deviation to 1.0; no clearing pass.
`default_nettype none

module box_muller_gaussian_sample_unit
  import bmg_pkg::*;
#(
  parameter int unsigned UNIFORM_BITS = 32,
  localparam int unsigned IN_W = ((2 * UNIFORM_BITS + 7) / 8) * 8,
  localparam int unsigned EW   = $clog2(UNIFORM_BITS + 1),
  localparam int unsigned SB   = (EW + 28 + 2 + 28 + 1) / 2,
  localparam int unsigned LR   = RAD_FIXED_STAGES + SB,
  localparam int unsigned DL   = LR - COS_LATENCY,
  localparam int unsigned PW   = SB + 5,
  localparam int unsigned MW   = PW + 3,
  localparam int unsigned SW   = MW + 2,
  localparam int unsigned NV   = LR + 3
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            s_axis_tvalid,
  output logic                 s_axis_tready,
  // radius_uniform, angle_uniform, zero fill
  input  wire logic [IN_W-1:0] s_axis_tdata,
  output logic                 m_axis_tvalid,
  input  wire logic            m_axis_tready,
  // gaussian_sample
  output logic      [31:0]     m_axis_tdata,
  // sample_saturated
  output logic                 m_axis_tuser,
  input  wire logic            cfg_valid_i,
  output logic                 cfg_ready_o,
  input  wire logic            cfg_index_i,
  input  wire logic [31:0]     cfg_data_i
);

  logic          en;
  logic [NV-1:0] vld_q;
  logic [31:0]   mean_q, std_q;
  logic [SB-1:0] s_w;
  logic          cneg_w;
  logic [31:0]   cmag_w;
  logic          cneg_dq [DL];
  logic [31:0]   cmag_dq [DL];
  logic [32+SB:0] pprod;
  logic [PW-1:0] p_q;
  logic          pneg_q;
  logic [31:0]   pmag_q;
  logic [PW-1:0] hi;
  logic [64:0]   lo;
  logic [MW-1:0] mag_q;
  logic          mneg_q;
  logic [SW-1:0] mean_ext, sum;
  logic          in_range;
  logic [31:0]   out_data_q;
  logic          out_sat_q;

  assign en            = m_axis_tready || !vld_q[NV-1];
  assign s_axis_tready = en;
  assign cfg_ready_o   = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mean_q <= '0;
      std_q  <= 32'h0001_0000;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_MEAN: mean_q <= cfg_data_i;
        CFG_STD:  std_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NV-2:0], s_axis_tvalid};
    end
  end

  bmg_radius #(.UNIFORM_BITS(UNIFORM_BITS)) u_radius (
    .clk_i  (clk_i),
    .en_i   (en),
    .code_i (s_axis_tdata[UNIFORM_BITS-1:0]),
    .s_o    (s_w)
  );

  bmg_cosine #(.UNIFORM_BITS(UNIFORM_BITS)) u_cosine (
    .clk_i   (clk_i),
    .en_i    (en),
    .code_i  (s_axis_tdata[2*UNIFORM_BITS-1:UNIFORM_BITS]),
    .c_neg_o (cneg_w),
    .c_mag_o (cmag_w)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      cneg_dq[0] <= cneg_w;
      cmag_dq[0] <= cmag_w;
      for (int i = 1; i < DL; i++) begin
        cneg_dq[i] <= cneg_dq[i-1];
        cmag_dq[i] <= cmag_dq[i-1];
      end
    end
  end

  assign pprod = (33+SB)'(std_q) * (33+SB)'(s_w) + ((33+SB)'(1) << 27);
  assign hi    = PW'(p_q[PW-1:32]) * PW'(pmag_q);
  assign lo    = 65'(p_q[31:0]) * 65'(pmag_q) + (65'(1) << 29);

  assign mean_ext = {{(SW-32){mean_q[31]}}, mean_q};
  assign sum      = mneg_q ? mean_ext - SW'(mag_q) : mean_ext + SW'(mag_q);
  assign in_range = (&sum[SW-1:31]) || !(|sum[SW-1:31]);

  always_ff @(posedge clk_i) begin
    if (en) begin
      p_q    <= pprod[32+SB:28];
      pneg_q <= cneg_dq[DL-1];
      pmag_q <= cmag_dq[DL-1];
      mag_q  <= MW'({hi, 2'b00}) + MW'(lo[64:30]);
      mneg_q <= pneg_q;
      if (in_range) begin
        out_data_q <= sum[31:0];
      end else begin
        out_data_q <= sum[SW-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end
      out_sat_q <= !in_range;
    end
  end

  assign m_axis_tvalid = vld_q[NV-1];
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_sat_q;

  a_sat_at_rail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |->
      m_axis_tdata == 32'h7FFF_FFFF || m_axis_tdata == 32'h8000_0000)
    else $error("saturation flag without a rail value");

  a_zero_dev: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[LR] && std_q == '0 |-> p_q == '0)
    else $error("zero deviation gave a nonzero scale");

  a_cos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[LR] |-> pmag_q <= 32'h4000_0100)
    else $error("cosine magnitude above one");

endmodule

`default_nettype wire

/* tb/bmg_checker.sv */
// Checker for the Gaussian sample unit: predicts each sample and compares the output stream.
`default_nettype none

module bmg_checker
  import bmg_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  input  wire logic        s_axis_tready,
  input  wire logic [63:0] s_axis_tdata,
  input  wire logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  input  wire logic [31:0] m_axis_tdata,
  input  wire logic        m_axis_tuser,
  input  wire logic        cfg_valid_i,
  input  wire logic        cfg_ready_o,
  input  wire logic        cfg_index_i,
  input  wire logic [31:0] cfg_data_i,
  output int               mismatches_o,
  output int               pending_o,
  output int               sat_seen_o
);

  typedef struct packed {
    logic [31:0] sample;
    logic        sat;
  } sample_t;

  sample_t     sample_q[$];
  logic [31:0] mean_reg;
  logic [31:0] std_reg;

  // -2 ln(u1), Q.28
  function automatic longint unsigned neg2_ln_q28(logic [31:0] code);
    longint unsigned x, m, f, t;
    int unsigned     e;
    x = 64'(code) + 1;
    e = 0;
    f = 0;
    while (e < 63 && (x >> (e + 1)) != 0) e++;
    m = (e >= 30) ? (x >> (e - 30)) : (x << (30 - e));
    for (int i = 27; i >= 0; i--) begin
      m = (m * m) >> 30;
      if (m >= 64'h8000_0000) begin
        m = m >> 1;
        f = f | (64'd1 << i);
      end
    end
    t = (64'(32 - e) << 28) - f;
    return (t * 64'(TWO_LN2_Q28) + (64'd1 << 27)) >> 28;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned root, b;
    root = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= root + b) begin
        n = n - (root + b);
        root = (root >> 1) + b;
      end else begin
        root = root >> 1;
      end
      b = b >> 2;
    end
    return root;
  endfunction

  function automatic longint taylor(longint unsigned t0, longint unsigned z2,
                                    longint unsigned a);
    longint          acc;
    longint unsigned term;
    acc = longint'(t0);
    term = t0;
    for (int k = 1; k <= 8; k++) begin
      term = (term * z2 + (64'd1 << 29)) >> 30;
      term = term / (a * (a + 1));
      a = a + 2;
      if (k % 2 == 1) acc = acc - longint'(term);
      else acc = acc + longint'(term);
    end
    return acc;
  endfunction

  // cos(2 pi u2), signed Q.30
  function automatic longint cos_q30(logic [31:0] code);
    longint unsigned r, z, z2, one;
    one = 64'(ONE_Q30);
    r = 64'(code[29:0]);
    z = (r * 64'(HALF_PI_Q30)) >> 30;
    z2 = (z * z + (one >> 1)) >> 30;
    case (code[31:30])
      2'd0:    return taylor(one, z2, 1);
      2'd1:    return -taylor(z, z2, 2);
      2'd2:    return -taylor(one, z2, 1);
      default: return taylor(z, z2, 2);
    endcase
  endfunction

  function automatic sample_t gaussian(logic [31:0] rad, logic [31:0] ang);
    longint unsigned s, p, ac, mag;
    longint          c, total;
    sample_t         res;
    s = int_sqrt(neg2_ln_q28(rad) << 28);
    c = cos_q30(ang);
    ac = (c < 0) ? longint'(-c) : longint'(c);
    p = (64'(std_reg) * s + (64'd1 << 27)) >> 28;
    mag = (p >> 32) * ac * 4 + (((p & 64'hFFFF_FFFF) * ac + (64'd1 << 29)) >> 30);
    total = longint'($signed(mean_reg));
    total = (c < 0) ? total - longint'(mag) : total + longint'(mag);
    res.sat = 1'b0;
    if (total > 64'sd2147483647) begin
      total = 64'sd2147483647;
      res.sat = 1'b1;
    end else if (total < -64'sd2147483648) begin
      total = -64'sd2147483648;
      res.sat = 1'b1;
    end
    res.sample = total[31:0];
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    sample_t exp_s;
    if (!rst_ni) begin
      mean_reg <= '0;
      std_reg <= 32'h0001_0000;
      mismatches_o <= 0;
      sat_seen_o <= 0;
      sample_q.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_reg_e'(cfg_index_i) == CFG_MEAN) mean_reg <= cfg_data_i;
        else std_reg <= cfg_data_i;
      end
      if (s_axis_tvalid && s_axis_tready)
        sample_q.push_back(gaussian(s_axis_tdata[31:0], s_axis_tdata[63:32]));
      if (m_axis_tvalid && m_axis_tready) begin
        if (sample_q.size() == 0) begin
          if (mismatches_o < 10) $display("checker: unexpected word %h", m_axis_tdata);
          mismatches_o <= mismatches_o + 1;
        end else begin
          exp_s = sample_q.pop_front();
          if (exp_s.sat) sat_seen_o <= sat_seen_o + 1;
          if (exp_s.sample !== m_axis_tdata || exp_s.sat !== m_axis_tuser) begin
            if (mismatches_o < 10)
              $display("checker: sample exp %h/%b got %h/%b", exp_s.sample, exp_s.sat,
                       m_axis_tdata, m_axis_tuser);
            mismatches_o <= mismatches_o + 1;
          end
        end
      end
    end
  end

  assign pending_o = sample_q.size();

endmodule

`default_nettype wire

/* tb/tb_top.sv */
// Testbench top: stimulus, output stalls and verdict for the Gaussian sample unit.
`default_nettype none

module tb_top;
  import bmg_pkg::*;

  localparam int DRAIN_CYCLES = 80;
  localparam int IDLE_LIMIT   = 3000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  cfg_reg_e    cfg_index_i = CFG_MEAN;
  logic [31:0] cfg_data_i = '0;

  int mismatches, pending, sat_seen;
  int items_sent = 0;
  int idle_cycles = 0;
  int out_wait = 0;
  bit no_gaps = 1'b0;

  always #2 clk_i = ~clk_i;

  box_muller_gaussian_sample_unit dut (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  bmg_checker u_checker (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .mismatches_o(mismatches), .pending_o(pending), .sat_seen_o(sat_seen)
  );

  // output side stalls; ready rises on the first cycle out of reset
  always @(posedge clk_i) begin
    int w;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        w = no_gaps ? 0 : $urandom_range(0, 8);
        if (w != 0) begin
          m_axis_tready <= 1'b0;
          out_wait <= w;
        end
      end else if (!m_axis_tready) begin
        if (out_wait <= 1) m_axis_tready <= 1'b1;
        else out_wait <= out_wait - 1;
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o) || !rst_ni)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles == IDLE_LIMIT) begin
      $display("tb_top: no handshake for %0d cycles", IDLE_LIMIT);
      $display("tb_top: done, errors");
      $finish;
    end
  end

  task automatic send(logic [31:0] rad, logic [31:0] ang);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 8);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {ang, rad};
    do @(posedge clk_i); while (!s_axis_tready);
    items_sent++;
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [31:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_regs(logic [31:0] mean, logic [31:0] sd);
    drain();
    write_reg(CFG_MEAN, mean);
    write_reg(CFG_STD, sd);
  endtask

  logic [31:0] rad_dir[4] = '{32'h0, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h1};
  logic [31:0] ang_dir[6] = '{32'h0, 32'h4000_0000, 32'h8000_0000, 32'hC000_0000,
                              32'hFFFF_FFFF, 32'h3FFF_FFFF};

  initial begin
    logic [31:0] mean, sd;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset settings, then field extremes
    for (int i = 0; i < 4; i++)
      for (int j = 0; j < 4; j++) send(rad_dir[i], ang_dir[j + (i % 3)]);
    set_regs(32'h7FFF_FFFF, 32'hFFFF_FFFF);
    for (int j = 0; j < 3; j++) send(32'h0, ang_dir[j]);
    set_regs(32'h8000_0000, 32'hFFFF_FFFF);
    for (int j = 0; j < 3; j++) send(32'h0, ang_dir[j]);
    set_regs(32'h0123_4567, 32'h0);
    send(32'h0, 32'h0);
    send($urandom, $urandom);

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin mean = $urandom; sd = $urandom; end
        1: begin mean = $urandom_range(0, 32'h000F_FFFF); sd = $urandom_range(0, 32'h0004_0000); end
        2: begin mean = 32'h8000_0000; sd = 32'h0100_0000; end
        3: begin mean = 32'hFFFF_0000; sd = 32'h0000_0001; end
        default: begin mean = $urandom; sd = $urandom_range(0, 32'h00FF_FFFF); end
      endcase
      set_regs(mean, sd);
      no_gaps = (ph == 2);
      for (int k = 0; k < 86; k++) begin
        if (k == 40) drain();
        send($urandom, $urandom);
      end
      no_gaps = 1'b0;
    end

    drain();
    $display("tb_top: %0d samples over nine register settings, %0d saturated",
             items_sent, sat_seen);
    $display("tb_top: covered uniform extremes, every quadrant, idle gaps and stalls");
    if (mismatches == 0)
      $display("tb_top: done, clean");
    else
      $display("tb_top: done, errors");
    $finish;
  end

endmodule

`default_nettype wire
